// ===== sv/rrb_pkg.sv =====
// Package for the receive ring buffer: sizes, action and status codes,
// sequencer state type. No dependencies.
`default_nettype none
package rrb_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int MAX_BLOCK    = 64;

  localparam int IDX_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int REM_W  = $clog2(MAX_BLOCK + 1);
  localparam int LEN_W  = 7;
  localparam int FILL_W = 9;
  localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam logic [2:0] ACT_RECEIVE = 3'd0;
  localparam logic [2:0] ACT_POP     = 3'd1;
  localparam logic [2:0] ACT_UNGET   = 3'd2;
  localparam logic [2:0] ACT_BLOCK   = 3'd3;
  localparam logic [2:0] ACT_FLUSH   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_BYTE
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             dec;
  } step_req_t;

endpackage
`default_nettype wire

// ===== sv/receive_ring_buffer_with_unget.sv =====
// Receive ring buffer with unget: top level, sequencer and output register; uses rrb_pkg,
// rrb_ram and rrb_step. Beats that return no byte (receive, unget, flush, unknown code, pop or
// block read on empty, zero-length block read): S_EXEC runs the action and loads the output
// register. Pop with data: S_EXEC issues the RAM read, S_BYTE loads the byte. Block read of
// n bytes: S_BYTE loads one per cycle while output is free. Beats are only taken in S_IDLE.
// Synchronous active-low reset clears pointers and count; the store is not cleared.
`default_nettype none
module receive_ring_buffer_with_unget
  import rrb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // byte_in[7:0], request_length[14:8], zero
  input  wire logic [2:0]  in_tuser,  // action[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // byte_out[7:0], fill_count[16:8], zero
  output logic [2:0]       out_tuser, // byte_valid[0], status[2:1]
  output logic             out_tlast
);

  state_t state_r, state_nxt;

  logic [2:0]       act_r;
  logic [7:0]       byte_r;
  logic [LEN_W-1:0] len_r;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;

  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_bv_r;
  logic [1:0]       out_status_r;
  logic             out_last_r;
  logic [FILL_W-1:0] out_fill_r;

  logic             load;
  logic [7:0]       ld_byte;
  logic             ld_bv;
  logic [1:0]       ld_status;
  logic             ld_last;

  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  logic [7:0]       wdata, rdata;

  step_req_t        step_req;
  logic [IDX_W-1:0] step_out;

  logic             accept, slot_free, full, empty, rem_one;
  logic [LEN_W-1:0] len_sat;
  logic [REM_W-1:0] clip;

  rrb_ram #(.DEPTH(BUFFER_DEPTH), .AW(IDX_W), .DW(8)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  rrb_step u_step (
    .req     (step_req),
    .idx_out (step_out)
  );

  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign full      = (count_r == CNT_W'(BUFFER_DEPTH));
  assign empty     = (count_r == '0);
  assign rem_one   = (rem_r == REM_W'(1));

  assign len_sat = (len_r > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : len_r;
  assign clip    = (CMP_W'(len_sat) > CMP_W'(count_r)) ? REM_W'(count_r) : REM_W'(len_sat);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (re) state_nxt = S_BYTE;
        else if (load) state_nxt = S_IDLE;
      end
      S_BYTE: begin
        if (load && rem_one) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = (state_r == S_IDLE);
    load          = 1'b0;
    ld_byte       = '0;
    ld_bv         = 1'b0;
    ld_status     = ST_OK;
    ld_last       = 1'b1;
    we            = 1'b0;
    waddr         = tail_r;
    wdata         = byte_r;
    re            = 1'b0;
    raddr         = head_r;
    step_req.idx  = head_r;
    step_req.dec  = 1'b0;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    case (state_r)
      S_EXEC: begin
        case (act_r)
          ACT_RECEIVE: begin
            step_req.idx = tail_r;
            if (slot_free) begin
              load = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                we        = 1'b1;
                tail_nxt  = step_out;
                count_nxt = count_r + 1'b1;
              end
            end
          end
          ACT_POP: begin
            if (empty) begin
              load      = slot_free;
              ld_status = ST_EMPTY;
            end else begin
              re      = 1'b1;
              rem_nxt = REM_W'(1);
            end
          end
          ACT_UNGET: begin
            step_req.dec = 1'b1;
            waddr        = step_out;
            if (slot_free) begin
              load = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                we        = 1'b1;
                head_nxt  = step_out;
                count_nxt = count_r + 1'b1;
              end
            end
          end
          ACT_BLOCK: begin
            if (empty) begin
              load      = slot_free;
              ld_status = ST_EMPTY;
            end else if (clip == '0) begin
              load = slot_free;
            end else begin
              re      = 1'b1;
              rem_nxt = clip;
            end
          end
          ACT_FLUSH: begin
            if (slot_free) begin
              load      = 1'b1;
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
            end
          end
          default: begin
            load = slot_free;
          end
        endcase
      end
      S_BYTE: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_byte   = rdata;
          ld_bv     = 1'b1;
          ld_last   = rem_one;
          head_nxt  = step_out;
          count_nxt = count_r - 1'b1;
          rem_nxt   = rem_r - 1'b1;
          if (!rem_one) begin
            re    = 1'b1;
            raddr = step_out;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_tuser;
      byte_r <= in_tdata[7:0];
      len_r  <= in_tdata[14:8];
    end
    if (load) begin
      out_byte_r   <= ld_byte;
      out_bv_r     <= ld_bv;
      out_status_r <= ld_status;
      out_last_r   <= ld_last;
      out_fill_r   <= FILL_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_fill_r, out_byte_r};
  assign out_tuser  = {out_status_r, out_bv_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== sv/rrb_ram.sv =====
// Byte store: simple dual-port RAM, one write and one registered read.
// Generic, no package dependency.
`default_nettype none
module rrb_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/rrb_step.sv =====
// Shared ring index unit: one step forwards or backwards with wrap.
// Depends on rrb_pkg.
`default_nettype none
module rrb_step
  import rrb_pkg::*;
(
  input  wire step_req_t        req,
  output logic      [IDX_W-1:0] idx_out
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_DEPTH - 1);

  always_comb begin
    if (req.dec) begin
      idx_out = (req.idx == '0) ? LAST_IDX : req.idx - 1'b1;
    end else begin
      idx_out = (req.idx == LAST_IDX) ? '0 : req.idx + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== dv/receive_ring_buffer_with_unget_test.sv =====
// Self-checking testbench for receive_ring_buffer_with_unget: drives action beats,
// predicts every result with its own ring model and checks each output beat.
// Depends on rrb_pkg and the RTL of the block.
`default_nettype none
module receive_ring_buffer_with_unget_test
  import rrb_pkg::*;
();

  localparam int CLK_PERIOD     = 8;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int MAX_PRINTED    = 40;

  localparam logic [2:0] ACT_SPARE_A = 3'd5;
  localparam logic [2:0] ACT_SPARE_B = 3'd6;
  localparam logic [2:0] ACT_SPARE_C = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [1:0] status;
    logic       last;
    logic [8:0] fill;
  } rx_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;  // byte_in[7:0], request_length[14:8], zero
  logic [2:0]  in_tuser = '0;  // action[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;      // byte_out[7:0], fill_count[16:8], zero
  logic [2:0]  out_tuser;      // byte_valid[0], status[2:1]
  logic        out_tlast;

  // ring model
  logic [7:0]       ring_bytes [BUFFER_DEPTH];
  logic [IDX_W-1:0] head_ptr = '0;
  logic [IDX_W-1:0] tail_ptr = '0;
  logic [8:0]       held_bytes = '0;

  rx_result_t pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int full_replies = 0;
  int empty_replies = 0;
  int peak_fill = 0;

  receive_ring_buffer_with_unget u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("ERROR @%0t: %s", $time, what);
    end
  endtask

  function automatic void queue_result(input logic [7:0] data, input logic valid,
                                       input logic [1:0] status, input logic last);
    rx_result_t r;
    r.data   = data;
    r.valid  = valid;
    r.status = status;
    r.last   = last;
    r.fill   = held_bytes;
    pending_results.push_back(r);
  endfunction

  function automatic logic [7:0] take_oldest_byte();
    logic [7:0] b;
    b = ring_bytes[head_ptr];
    head_ptr = (head_ptr == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : head_ptr + 1'b1;
    held_bytes--;
    return b;
  endfunction

  function automatic void predict_ring_action(input logic [2:0] act, input logic [7:0] b,
                                              input logic [6:0] len);
    int n;
    case (act)
      ACT_RECEIVE: begin
        if (held_bytes == BUFFER_DEPTH) begin
          queue_result('0, 1'b0, ST_FULL, 1'b1);
        end else begin
          ring_bytes[tail_ptr] = b;
          tail_ptr = (tail_ptr == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : tail_ptr + 1'b1;
          held_bytes++;
          queue_result('0, 1'b0, ST_OK, 1'b1);
        end
      end
      ACT_POP: begin
        if (held_bytes == 0) begin
          queue_result('0, 1'b0, ST_EMPTY, 1'b1);
        end else begin
          queue_result(take_oldest_byte(), 1'b1, ST_OK, 1'b1);
        end
      end
      ACT_UNGET: begin
        if (held_bytes == BUFFER_DEPTH) begin
          queue_result('0, 1'b0, ST_FULL, 1'b1);
        end else begin
          head_ptr = (head_ptr == '0) ? IDX_W'(BUFFER_DEPTH - 1) : head_ptr - 1'b1;
          ring_bytes[head_ptr] = b;
          held_bytes++;
          queue_result('0, 1'b0, ST_OK, 1'b1);
        end
      end
      ACT_BLOCK: begin
        n = (len > MAX_BLOCK) ? MAX_BLOCK : int'(len);
        if (n > held_bytes) n = held_bytes;
        if (held_bytes == 0) begin
          queue_result('0, 1'b0, ST_EMPTY, 1'b1);
        end else if (n == 0) begin
          queue_result('0, 1'b0, ST_OK, 1'b1);
        end else begin
          for (int k = 0; k < n; k++) begin
            queue_result(take_oldest_byte(), 1'b1, ST_OK, k == n - 1);
          end
        end
      end
      ACT_FLUSH: begin
        head_ptr = '0;
        tail_ptr = '0;
        held_bytes = '0;
        queue_result('0, 1'b0, ST_OK, 1'b1);
      end
      default: queue_result('0, 1'b0, ST_OK, 1'b1);
    endcase
    if (held_bytes > peak_fill) peak_fill = held_bytes;
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_action(input logic [2:0] act, input logic [7:0] b,
                             input logic [6:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {1'b0, len, b};
    do @(posedge clk); while (!in_tready);
    predict_ring_action(act, b, len);
    beats_sent++;
  endtask

  always @(posedge clk) begin : result_check
    rx_result_t got;
    rx_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[7:0], out_tuser[0], out_tuser[2:1], out_tlast, out_tdata[16:8]};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte=%h valid=%b status=%0d last=%b fill=%0d",
                                  got.data, got.valid, got.status, got.last, got.fill));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.status == ST_FULL) full_replies++;
        if (want.status == ST_EMPTY) empty_replies++;
        if (got !== want) begin
          report_mismatch($sformatf(
            "byte %h/%h valid %b/%b status %0d/%0d last %b/%b fill %0d/%0d (got/exp)",
            got.data, want.data, got.valid, want.valid, got.status, want.status,
            got.last, want.last, got.fill, want.fill));
        end
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic test_empty_and_edges;
    send_action(ACT_POP,     8'h00, 7'd0);
    send_action(ACT_BLOCK,   8'hFF, 7'd5);
    send_action(ACT_BLOCK,   8'h00, 7'd0);
    send_action(ACT_SPARE_A, 8'hFF, 7'd127);
    send_action(ACT_SPARE_B, 8'h00, 7'd64);
    send_action(ACT_SPARE_C, 8'hA5, 7'd1);
    send_action(ACT_FLUSH,   8'h5A, 7'd65);
    send_action(ACT_RECEIVE, 8'h00, 7'd0);
    send_action(ACT_RECEIVE, 8'hFF, 7'd127);
    send_action(ACT_RECEIVE, 8'h55, 7'd42);
    send_action(ACT_RECEIVE, 8'hAA, 7'd85);
    send_action(ACT_UNGET,   8'h81, 7'd0);
    send_action(ACT_BLOCK,   8'h00, 7'd0);    // data held, nothing removed
    send_action(ACT_POP,     8'h00, 7'd0);
    send_action(ACT_BLOCK,   8'h00, 7'd2);
    send_action(ACT_UNGET,   8'h7E, 7'd0);
    send_action(ACT_BLOCK,   8'h00, 7'd127);  // saturated, then clipped to fill
    send_action(ACT_RECEIVE, 8'h11, 7'd0);
    send_action(ACT_RECEIVE, 8'h22, 7'd0);
    send_action(ACT_FLUSH,   8'h00, 7'd0);
    send_action(ACT_POP,     8'h00, 7'd0);
    send_action(ACT_UNGET,   8'h5A, 7'd0);    // head wraps below index zero
    send_action(ACT_BLOCK,   8'h00, 7'd65);
  endtask

  task automatic test_fill_and_drain;
    send_action(ACT_FLUSH, 8'h00, 7'd0);
    for (int k = 0; k < 60; k++) begin
      send_action((k % 3 == 0) ? ACT_UNGET : ACT_RECEIVE,
                  8'($urandom_range(255)), 7'($urandom_range(127)));
    end
    send_action(ACT_BLOCK,   8'h00, 7'd20);
    send_action(ACT_UNGET,   8'hE7, 7'd0);
    send_action(ACT_RECEIVE, 8'h18, 7'd0);
    send_action(ACT_POP,     8'h00, 7'd0);
    while (held_bytes != 0) begin
      send_action(ACT_BLOCK, 8'($urandom_range(255)), 7'($urandom_range(127, 40)));
    end
    send_action(ACT_POP, 8'h00, 7'd0);
  endtask

  task automatic run_random_traffic(input int count);
    int pick;
    logic [6:0] len;
    repeat (count) begin
      pick = $urandom_range(99);
      len = 7'($urandom_range(127));
      if (pick < 40) begin
        send_action(ACT_RECEIVE, 8'($urandom_range(255)), len);
      end else if (pick < 52) begin
        send_action(ACT_UNGET, 8'($urandom_range(255)), len);
      end else if (pick < 67) begin
        send_action(ACT_POP, 8'($urandom_range(255)), len);
      end else if (pick < 92) begin
        if ($urandom_range(7) != 0) len = 7'($urandom_range(12));
        send_action(ACT_BLOCK, 8'($urandom_range(255)), len);
      end else if (pick < 96) begin
        send_action(ACT_FLUSH, 8'($urandom_range(255)), len);
      end else begin
        send_action(3'($urandom_range(ACT_SPARE_C, ACT_SPARE_A)),
                    8'($urandom_range(255)), len);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 37;
    recv_idle_pct = 88;
    test_empty_and_edges();
    run_random_traffic(27);

    send_idle_pct = 88;
    recv_idle_pct = 37;
    test_fill_and_drain();
    run_random_traffic(27);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_traffic(27);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d action beats, checked %0d results; peak fill %0d of %0d,",
             beats_sent, results_checked, peak_fill, BUFFER_DEPTH);
    $display("%0d full replies, %0d empty replies, %0d mismatches.",
             full_replies, empty_replies, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("receive_ring_buffer_with_unget_test: PASS");
    end else begin
      $display("receive_ring_buffer_with_unget_test: FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("receive_ring_buffer_with_unget_test: FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/rrb_pkg.sv
sv/rrb_ram.sv
sv/rrb_step.sv
sv/receive_ring_buffer_with_unget.sv
dv/receive_ring_buffer_with_unget_test.sv
